### src/dq_pkg.sv
`default_nettype none
package dq_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = AW + 1;
	localparam int WW    = 32;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_POP_FRONT  = 2'd1,
		CMD_PUSH_BACK  = 2'd2,
		CMD_POP_BACK   = 2'd3
	} cmd_t;

	// outcome of one ring operation, registered and valid in the cycle after the transfer
	typedef struct packed {
		logic pop_hit;
		logic was_empty;
		logic overflow;
	} ring_stat_t;

endpackage
`default_nettype wire

### src/dq_ring.sv
`default_nettype none
module dq_ring (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       matched,
	input  dq_pkg::cmd_t              cmd,
	input  wire  [dq_pkg::WW-1:0]     value,
	output logic [dq_pkg::WW-1:0]     rd_data_s1,
	output dq_pkg::ring_stat_t        stat_s1
);
	import dq_pkg::*;

	logic [WW-1:0] mem [DEPTH];

	logic [AW-1:0] front_q, front_n;
	logic [CW-1:0] count_q, count_n;
	logic          full, empty, act;
	logic [AW-1:0] front_dec, front_inc, back_idx;
	logic [CW-1:0] back_sum, back_wrap;
	logic          wr_en, rd_en;
	logic [AW-1:0] addr;
	ring_stat_t    stat_n;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign act   = en && matched;

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// back slot for a push sits at front+count, the back element at front+count-1
	assign back_sum  = {1'b0, front_q} + count_q - CW'(cmd == CMD_POP_BACK);
	assign back_wrap = (back_sum >= CW'(DEPTH)) ? back_sum - CW'(DEPTH) : back_sum;
	assign back_idx  = back_wrap[AW-1:0];

	always_comb begin
		front_n = front_q;
		count_n = count_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		addr    = front_q;
		stat_n  = '0;
		if (act) begin
			unique case (cmd)
				CMD_PUSH_FRONT: begin
					if (full) begin
						stat_n.overflow = 1'b1;
					end else begin
						wr_en   = 1'b1;
						addr    = front_dec;
						front_n = front_dec;
						count_n = count_q + CW'(1);
					end
				end
				CMD_PUSH_BACK: begin
					if (full) begin
						stat_n.overflow = 1'b1;
					end else begin
						wr_en   = 1'b1;
						addr    = back_idx;
						count_n = count_q + CW'(1);
					end
				end
				CMD_POP_FRONT: begin
					if (empty) begin
						stat_n.was_empty = 1'b1;
					end else begin
						rd_en          = 1'b1;
						addr           = front_q;
						front_n        = front_inc;
						count_n        = count_q - CW'(1);
						stat_n.pop_hit = 1'b1;
					end
				end
				CMD_POP_BACK: begin
					if (empty) begin
						stat_n.was_empty = 1'b1;
					end else begin
						rd_en          = 1'b1;
						addr           = back_idx;
						count_n        = count_q - CW'(1);
						stat_n.pop_hit = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			front_q <= front_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= value;
		if (rd_en)
			rd_data_s1 <= mem[addr];
		if (en)
			stat_s1 <= stat_n;
	end

endmodule
`default_nettype wire

### src/deque_with_pop_check.sv
`default_nettype none
// Double-ended queue of signed 32-bit words held in a ring memory of DEPTH entries
// (dq_pkg), with a check of every pop against the word carried by the item. Each
// input transfer is a push or pop at either end and gives exactly one output
// transfer, via the ring read stage and the output register when the output is free.
// A push, and any item after a mismatch, lets the next item follow unless the output
// is blocked; a pop holds the next item until its word, read from the single-port
// ring memory, is compared and settles all_matched. A pop on an empty queue returns
// -1 with was_empty set; a push on a full queue is dropped with overflow set. Once
// a pop mismatches, all_matched drops for good and later items return zeros
// without touching the queue. No memory initialization is needed after reset.
module deque_with_pop_check (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  cmd,
	input  wire  signed [31:0] value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic signed [31:0] popped,
	output logic        was_empty,
	output logic        overflow,
	output logic        all_matched
);
	import dq_pkg::*;

	logic          accept, s1_adv, out_xfer;
	logic          s1_valid_q, s1_chk_q;
	logic [WW-1:0] exp_s1;
	logic [WW-1:0] rd_data_s1;
	ring_stat_t    stat_s1;
	logic          matched_q;
	logic [WW-1:0] popped_w;
	logic          mismatch;
	logic          out_valid_q;
	logic [WW-1:0] popped_q;
	logic          was_empty_q, overflow_q, all_matched_q;
	cmd_t          cmd_w;

	assign cmd_w    = cmd_t'(cmd);
	assign out_xfer = out_valid_q && !out_stall;
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	// hold input behind a pop until its compare has settled the match flag
	assign in_stall = s1_valid_q && (s1_chk_q || !s1_adv);
	assign accept   = in_valid && !in_stall;

	dq_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.matched    (matched_q),
		.cmd        (cmd_w),
		.value      (value),
		.rd_data_s1 (rd_data_s1),
		.stat_s1    (stat_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_chk_q   <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			s1_chk_q   <= matched_q && (cmd_w == CMD_POP_FRONT || cmd_w == CMD_POP_BACK);
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
			s1_chk_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			exp_s1 <= value;
	end

	always_comb begin
		if (stat_s1.pop_hit)
			popped_w = rd_data_s1;
		else if (stat_s1.was_empty)
			popped_w = '1;
		else
			popped_w = '0;
	end

	assign mismatch = s1_chk_q && (popped_w != exp_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv && mismatch)
				matched_q <= 1'b0;
			if (s1_adv)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			popped_q      <= popped_w;
			was_empty_q   <= stat_s1.was_empty;
			overflow_q    <= stat_s1.overflow;
			all_matched_q <= matched_q && !mismatch;
		end
	end

	assign out_valid   = out_valid_q;
	assign popped      = popped_q;
	assign was_empty   = was_empty_q;
	assign overflow    = overflow_q;
	assign all_matched = all_matched_q;

endmodule
`default_nettype wire

### src/dq_check.sv
`default_nettype none
module dq_check (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] popped,
	input wire        was_empty,
	input wire        overflow,
	input wire        all_matched
);

	// once the match flag drops it never comes back before reset
	a_match_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !all_matched) |=> !(out_valid && all_matched))
		else $error("all_matched rose again after a mismatch");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && was_empty) |-> (popped == 32'hFFFF_FFFF))
		else $error("empty pop did not return -1");

	a_push_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (!was_empty && popped == 32'd0))
		else $error("dropped push carried pop fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(popped)))
		else $error("stalled output transfer changed");

endmodule

bind deque_with_pop_check dq_check u_dq_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.popped      (popped),
	.was_empty   (was_empty),
	.overflow    (overflow),
	.all_matched (all_matched)
);
`default_nettype wire
